@@ design/sensor_slot_scheduler_macros.svh @@
// Assertion macros shared by the sensor slot scheduler checker.
`ifndef SENSOR_SLOT_SCHEDULER_MACROS_SVH
`define SENSOR_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sss assertion failed");

// Next-cycle implication, disabled while in reset.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sss assertion failed");

`endif

@@ design/sss_pkg.sv @@
// Types, codes and constants of the sensor slot scheduler.
package sss_pkg;

    localparam int NUM_SENSORS = 5;
    localparam int NUM_SLOTS   = 6;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 32;
    localparam int TIME_W      = 16;
    localparam int GRACE_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SLOT_W-1:0]      START_SLOT = SLOT_W'(1 % NUM_SLOTS);
    localparam logic [SLOT_W-1:0]      LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [TIME_W-1:0]      TIME_MAX   = {TIME_W{1'b1}};

    localparam logic [NUM_SENSORS-1:0] ENABLE_MASK_RST = NUM_SENSORS'(22);
    localparam logic [TIME_W-1:0]      SLOT_TICKS_RST  = TIME_W'(100);
    localparam logic [GRACE_W-1:0]     GRACE_TICKS_RST = GRACE_W'(20);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_START       = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_PAUSE       = 3'd3,
        CMD_RESUME      = 3'd4,
        CMD_FORCE_NEXT  = 3'd5,
        CMD_CLEAR_STATS = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_ACTIVE  = 2'd1,
        RUN_PAUSED  = 2'd2
    } run_state_t;

    localparam logic [2:0] DMA_BUSY     = 3'd1;
    localparam logic [2:0] DMA_COMPLETE = 3'd2;
    localparam logic [2:0] DMA_ERROR    = 3'd3;
    localparam logic [2:0] DMA_TIMEOUT  = 3'd4;

    localparam logic [1:0] REPLY_OK   = 2'd0;
    localparam logic [1:0] REPLY_BUSY = 2'd1;

    typedef struct packed {
        logic              clear;
        logic              grade_ok;
        logic              grade_miss;
        logic              grade_err;
        logic              req_miss;
        logic              req_err;
        logic [TIME_W-1:0] read_time;
    } lane_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]  success;
        logic [CNT_W-1:0]  missed;
        logic [CNT_W-1:0]  errors;
        logic [TIME_W-1:0] avg_time;
        logic [TIME_W-1:0] max_time;
    } lane_stats_t;

endpackage

@@ design/sss_stats_lane.sv @@
// Statistics registers and update logic of one sensor.
module sss_stats_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sss_pkg::lane_ctrl_t  ctrl,
    output sss_pkg::lane_stats_t stats_next
);

    sss_pkg::lane_stats_t stats_reg;
    logic [1:0]                miss_add;
    logic [1:0]                err_add;
    logic [sss_pkg::TIME_W:0]  avg_sum;

    always_comb begin
        miss_add = {1'b0, ctrl.grade_miss} + {1'b0, ctrl.req_miss};
        err_add  = {1'b0, ctrl.grade_err} + {1'b0, ctrl.req_err};
        avg_sum  = {1'b0, stats_reg.avg_time} + {1'b0, ctrl.read_time};
        stats_next = stats_reg;
        if (ctrl.clear) begin
            stats_next = '0;
        end else begin
            stats_next.success = stats_reg.success + sss_pkg::CNT_W'(ctrl.grade_ok);
            stats_next.missed  = stats_reg.missed + sss_pkg::CNT_W'(miss_add);
            stats_next.errors  = stats_reg.errors + sss_pkg::CNT_W'(err_add);
            if (ctrl.grade_ok) begin
                stats_next.avg_time = avg_sum[sss_pkg::TIME_W:1];
                if (ctrl.read_time > stats_reg.max_time) begin
                    stats_next.max_time = ctrl.read_time;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else begin
            stats_reg <= stats_next;
        end
    end

endmodule

@@ design/sensor_slot_scheduler.sv @@
// Top level of the sensor slot scheduler: command decode, slot timing and result register.
// One command or tick is taken per clock unless the result register is stalled; its result is
// registered in the input register, then the result register, before it is presented.
// Sustained rate is one item per cycle while m_tready stays high,
// set by the combinational slot, grading and statistics update between those registers.
// Statistics live in flip-flops and are cleared by reset at once, so no clearing pass runs.
// Configuration writes take effect on the next clock and are meant for idle periods only.
module sensor_slot_scheduler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // query_sensor, dma_state, start_reply
    input  logic [2:0]                          s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // start_request, request_sensor, slot_now, running, slot_overrun, cycle_count,
    // query_success, query_missed, query_errors, query_avg_time, query_max_time, zero pad
    output logic [175:0]                        m_tdata
);

    localparam int NS = sss_pkg::NUM_SENSORS;
    localparam int SW = sss_pkg::SLOT_W;
    localparam int TW = sss_pkg::TIME_W;

    // configuration
    logic [NS-1:0]               enable_mask_reg;
    logic [TW-1:0]               slot_ticks_reg;
    logic [sss_pkg::GRACE_W-1:0] grace_ticks_reg;

    // input register
    logic                        in_valid_reg, in_valid_next;
    sss_pkg::cmd_t               in_cmd_reg;
    logic [2:0]                  in_query_reg;
    logic [2:0]                  in_dma_reg;
    logic [1:0]                  in_reply_reg;

    // scheduler state
    sss_pkg::run_state_t         run_reg, run_next;
    logic [SW-1:0]               slot_reg, slot_next;
    logic [TW-1:0]               tsc_reg, tsc_next;
    logic [TW-1:0]               tis_reg, tis_next;
    logic [sss_pkg::CNT_W-1:0]   cyc_reg, cyc_next;

    // result register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [175:0]                m_tdata_reg, m_tdata_next;

    logic                        consume;
    logic [TW-1:0]               tsc_inc;
    logic [TW-1:0]               tis_inc;
    logic [TW-1:0]               read_time;
    logic [SW-1:0]               slot_adv;
    logic                        do_grade;
    logic                        do_run;
    logic                        do_clear;
    logic [NS-1:0]               lane_req;
    logic                        req;
    logic [SW-1:0]               req_sensor;
    logic                        overrun;
    logic [TW:0]                 overrun_limit;
    sss_pkg::lane_ctrl_t         lane_ctrl  [NS];
    sss_pkg::lane_stats_t        lane_stats [NS];
    sss_pkg::lane_stats_t        query_stats;

    assign consume  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        tsc_inc   = (tsc_reg == sss_pkg::TIME_MAX) ? tsc_reg : tsc_reg + 1'b1;
        tis_inc   = (tis_reg == sss_pkg::TIME_MAX) ? tis_reg : tis_reg + 1'b1;
        slot_adv  = (slot_reg == sss_pkg::LAST_SLOT) ? '0 : slot_reg + 1'b1;
        run_next  = run_reg;
        slot_next = slot_reg;
        tsc_next  = tsc_reg;
        tis_next  = tis_reg;
        cyc_next  = cyc_reg;
        read_time = tis_reg;
        do_grade  = 1'b0;
        do_run    = 1'b0;
        do_clear  = 1'b0;
        unique case (in_cmd_reg)
            sss_pkg::CMD_TICK: begin
                tsc_next  = tsc_inc;
                tis_next  = tis_inc;
                read_time = tis_inc;
                do_grade  = (run_reg == sss_pkg::RUN_ACTIVE) && (tsc_inc >= slot_ticks_reg);
            end
            sss_pkg::CMD_START: begin
                slot_next = sss_pkg::START_SLOT;
                run_next  = sss_pkg::RUN_ACTIVE;
                tsc_next  = '0;
                tis_next  = '0;
                do_run    = 1'b1;
            end
            sss_pkg::CMD_STOP:   run_next = sss_pkg::RUN_STOPPED;
            sss_pkg::CMD_PAUSE:  run_next = sss_pkg::RUN_PAUSED;
            sss_pkg::CMD_RESUME: begin
                run_next = sss_pkg::RUN_ACTIVE;
                tsc_next = '0;
            end
            sss_pkg::CMD_FORCE_NEXT:  do_grade = 1'b1;
            sss_pkg::CMD_CLEAR_STATS: begin
                do_clear = 1'b1;
                cyc_next = '0;
            end
            default: ;
        endcase
        if (do_grade) begin
            slot_next = slot_adv;
            tsc_next  = '0;
            tis_next  = '0;
            do_run    = 1'b1;
            if (slot_adv == '0) begin
                cyc_next = cyc_reg + 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            lane_req[i] = do_run && (slot_next == SW'(i)) && enable_mask_reg[i];
            lane_ctrl[i].clear      = consume && do_clear;
            lane_ctrl[i].grade_ok   = consume && do_grade && (slot_reg == SW'(i))
                                      && (in_dma_reg == sss_pkg::DMA_COMPLETE);
            lane_ctrl[i].grade_miss = consume && do_grade && (slot_reg == SW'(i))
                                      && (in_dma_reg == sss_pkg::DMA_BUSY);
            lane_ctrl[i].grade_err  = consume && do_grade && (slot_reg == SW'(i))
                                      && ((in_dma_reg == sss_pkg::DMA_ERROR)
                                          || (in_dma_reg == sss_pkg::DMA_TIMEOUT));
            lane_ctrl[i].req_miss   = consume && lane_req[i]
                                      && (in_reply_reg == sss_pkg::REPLY_BUSY);
            lane_ctrl[i].req_err    = consume && lane_req[i]
                                      && (in_reply_reg != sss_pkg::REPLY_OK)
                                      && (in_reply_reg != sss_pkg::REPLY_BUSY);
            lane_ctrl[i].read_time  = read_time;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_lane
        sss_stats_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (lane_ctrl[g]),
            .stats_next (lane_stats[g])
        );
    end

    always_comb begin
        query_stats = '0;
        for (int i = 0; i < NS; i++) begin
            if (in_query_reg == 3'(i)) begin
                query_stats = lane_stats[i];
            end
        end
        req           = |lane_req;
        req_sensor    = req ? slot_next : '0;
        overrun_limit = {1'b0, slot_ticks_reg} + (TW+1)'(grace_ticks_reg);
        overrun       = (run_next == sss_pkg::RUN_ACTIVE) && ({1'b0, tis_next} > overrun_limit);
        m_tdata_next  = {7'd0,
                         query_stats.max_time,
                         query_stats.avg_time,
                         query_stats.errors,
                         query_stats.missed,
                         query_stats.success,
                         cyc_next,
                         overrun,
                         (run_next == sss_pkg::RUN_ACTIVE),
                         3'(slot_next),
                         3'(req_sensor),
                         req};
        m_tvalid_next = consume ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg <= sss_pkg::ENABLE_MASK_RST;
            slot_ticks_reg  <= sss_pkg::SLOT_TICKS_RST;
            grace_ticks_reg <= sss_pkg::GRACE_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sss_pkg::REG_ENABLE_MASK: enable_mask_reg <= cfg_wdata[NS-1:0];
                sss_pkg::REG_SLOT_TICKS:  slot_ticks_reg  <= cfg_wdata[TW-1:0];
                sss_pkg::REG_GRACE_TICKS: grace_ticks_reg <= cfg_wdata[sss_pkg::GRACE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            run_reg      <= sss_pkg::RUN_STOPPED;
            slot_reg     <= '0;
            tsc_reg      <= '0;
            tis_reg      <= '0;
            cyc_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (consume) begin
                run_reg  <= run_next;
                slot_reg <= slot_next;
                tsc_reg  <= tsc_next;
                tis_reg  <= tis_next;
                cyc_reg  <= cyc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= sss_pkg::cmd_t'(s_tuser);
            in_query_reg <= s_tdata[2:0];
            in_dma_reg   <= s_tdata[5:3];
            in_reply_reg <= s_tdata[7:6];
        end
        if (consume) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

@@ design/sss_checker.sv @@
// Port-level assertion checker of the sensor slot scheduler and its bind.
`include "sensor_slot_scheduler_macros.svh"

module sss_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata
);

    `SSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SSS_ASSERT_NOW(a_no_req_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[3:1] == 3'd0)
    `SSS_ASSERT_NOW(a_req_slot, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[3:1] == m_tdata[6:4])
    `SSS_ASSERT_NOW(a_overrun_run, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[7])
    `SSS_ASSERT_NOW(a_avg_le_max, aclk, aresetn, m_tvalid, m_tdata[152:137] <= m_tdata[168:153])

endmodule

bind sensor_slot_scheduler sss_checker u_sss_checker (.*);
